// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by bpc_div and bpc_press
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active
`define BPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication form, antecedent and consequent given separately
`define BPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
// ---------------------------------------------------------------------------
// bpc_pkg
// Types, constants and helpers of the pressure compensation pipeline.
// ---------------------------------------------------------------------------
package bpc_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_COEF_A = 2'd0,
    REG_COEF_B = 2'd1,
    REG_COEF_C = 2'd2,
    REG_OSS    = 2'd3
  } reg_idx_e;

  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned RawTempW  = 16;
  localparam int unsigned RawPressW = 19;
  localparam int unsigned TempW     = 16;
  localparam int unsigned PressW    = 18;

  localparam logic signed [31:0] B5_OFFSET   = 32'sd4000;
  localparam logic signed [31:0] B4_OFFSET   = 32'sd32768;
  localparam logic [31:0]        PRESS_SCALE = 32'd50000;
  localparam logic signed [31:0] PC_SQ       = 32'sd3038;
  localparam logic signed [31:0] PC_LIN      = -32'sd7357;
  localparam logic signed [31:0] PC_OFS      = 32'sd3791;
  localparam logic signed [31:0] PRESS_MAX   = 32'sd262143;

  // calibration words, widened to 32-bit signed
  typedef struct packed {
    logic signed [31:0] ac1;
    logic signed [31:0] ac2;
    logic signed [31:0] ac3;
    logic signed [31:0] ac4;
    logic signed [31:0] ac5;
    logic signed [31:0] ac6;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] mc;
    logic signed [31:0] md;
    logic [1:0]         oss;
  } coef_t;

  // word handed from the temperature part to the pressure part
  typedef struct packed {
    logic                     fault;
    logic signed [31:0]       b5;
    logic signed [TempW-1:0]  t;
    logic [RawPressW-1:0]     up;
  } temp_item_t;

  function automatic logic signed [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic signed [31:0] zext16(input logic [15:0] v);
    return {16'd0, v};
  endfunction

  // low 32 bits of a 32 x 32 product
  function automatic logic signed [31:0] mul_lo(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] f;
    f = a * b;
    return f[31:0];
  endfunction

endpackage

// ===== rtl/bpc_div.sv =====
// ---------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module bpc_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] nq_q   [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   shift;
    logic [DW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign nq_in   = nq_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    // bring down next numerator bit, trial subtract
    always_comb begin
      shift = {rem_in, nq_in[NW-1]};
      diff  = shift - {1'b0, den_in};
      ge    = (shift >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= ge ? diff[DW-1:0] : shift[DW-1:0];
        nq_q[s]   <= {nq_in[NW-2:0], ge};
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[NW-1];
  assign quo_o  = nq_q[NW-1];
  assign side_o = side_q[NW-1];

  `BPC_ASSERT(a_div_hold, !adv_i |=> $stable(vld_q[NW-1]), "divider moved while held")
  `BPC_ASSERT(a_div_shift, adv_i |=> (vld_q[NW-1] == $past(vld_q[NW-2])),
              "divider valid lost on advance")

endmodule

// ===== rtl/bpc_temp.sv =====
// ---------------------------------------------------------------------------
// bpc_temp
// Temperature half: B5 through a pipelined signed divide, saturated tenths.
// ---------------------------------------------------------------------------
module bpc_temp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             vld_i,
  input  logic [bpc_pkg::RawTempW-1:0]     raw_temp_i,
  input  logic [bpc_pkg::RawPressW-1:0]    raw_press_i,
  input  bpc_pkg::coef_t                   coef_i,
  output logic                             vld_o,
  output bpc_pkg::temp_item_t              item_o
);
  import bpc_pkg::*;

  localparam int unsigned QW = 27;

  typedef struct packed {
    logic                 qneg;
    logic                 fault;
    logic signed [31:0]   x1;
    logic [RawPressW-1:0] up;
  } tdiv_side_t;

  localparam int unsigned SW = $bits(tdiv_side_t);

  // stage 1: capture input word
  logic                 v1_q;
  logic [RawTempW-1:0]  ut1_q;
  logic [RawPressW-1:0] up1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ut1_q <= raw_temp_i;
      up1_q <= raw_press_i;
    end
  end

  // stage 2: X1 = ((UT - AC6) * AC5) >> 15
  logic                 v2_q;
  logic signed [31:0]   x1_2_q;
  logic [RawPressW-1:0] up2_q;
  logic signed [31:0]   x1_2_d;

  assign x1_2_d = mul_lo(zext16(ut1_q) - coef_i.ac6, coef_i.ac5) >>> 15;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x1_2_q <= x1_2_d;
      up2_q  <= up1_q;
    end
  end

  // stage 3: divisor X1 + MD
  logic                 v3_q;
  logic signed [31:0]   x1_3_q;
  logic signed [31:0]   den3_q;
  logic [RawPressW-1:0] up3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x1_3_q <= x1_2_q;
      den3_q <= x1_2_q + coef_i.md;
      up3_q  <= up2_q;
    end
  end

  // magnitudes into the divider, sign travels alongside
  logic signed [QW-1:0] num;
  logic [QW-1:0]        num_abs;
  logic [31:0]          den_abs;
  tdiv_side_t           side_in;
  tdiv_side_t           side_out;
  logic                 dv_vld;
  logic [QW-1:0]        quo;

  always_comb begin
    num           = {coef_i.mc[15:0], 11'd0};
    num_abs       = num[QW-1] ? QW'(-num) : QW'(num);
    den_abs       = den3_q[31] ? 32'(-den3_q) : 32'(den3_q);
    side_in.qneg  = num[QW-1] ^ den3_q[31];
    side_in.fault = (den3_q == 32'sd0);
    side_in.x1    = x1_3_q;
    side_in.up    = up3_q;
  end

  bpc_div #(
    .NW(QW),
    .DW(32),
    .SW(SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv_i),
    .vld_i  (v3_q),
    .num_i  (num_abs),
    .den_i  (den_abs),
    .side_i (side_in),
    .vld_o  (dv_vld),
    .quo_o  (quo),
    .side_o (side_out)
  );

  // post 1: B5 = X1 + X2
  logic                 v4_q;
  logic signed [31:0]   b5_4_q;
  logic                 f4_q;
  logic [RawPressW-1:0] up4_q;
  logic signed [31:0]   x2_mag;

  assign x2_mag = {{(32-QW){1'b0}}, quo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b5_4_q <= side_out.x1 + (side_out.qneg ? -x2_mag : x2_mag);
      f4_q   <= side_out.fault;
      up4_q  <= side_out.up;
    end
  end

  // post 2: (B5 + 8) >> 4, saturated
  logic                 v5_q;
  temp_item_t           item5_q;
  logic signed [31:0]   t_full;
  logic signed [TempW-1:0] t_sat;

  always_comb begin
    t_full = (b5_4_q + 32'sd8) >>> 4;
    if (t_full > 32'sd32767) begin
      t_sat = 16'sh7fff;
    end else if (t_full < -32'sd32768) begin
      t_sat = 16'sh8000;
    end else begin
      t_sat = t_full[TempW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item5_q.fault <= f4_q;
      item5_q.b5    <= b5_4_q;
      item5_q.t     <= t_sat;
      item5_q.up    <= up4_q;
    end
  end

  assign vld_o  = v5_q;
  assign item_o = item5_q;

endmodule

// ===== rtl/bpc_press.sv =====
// ---------------------------------------------------------------------------
// bpc_press
// Pressure half: B6..B7, pipelined unsigned divide, final correction.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module bpc_press (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                vld_i,
  input  bpc_pkg::temp_item_t                 item_i,
  input  bpc_pkg::coef_t                      coef_i,
  output logic                                vld_o,
  output logic signed [bpc_pkg::TempW-1:0]    temp_o,
  output logic [bpc_pkg::PressW-1:0]          press_o,
  output logic                                fault_o
);
  import bpc_pkg::*;

  typedef struct packed {
    logic                    fault;
    logic signed [TempW-1:0] t;
  } carry_t;

  typedef struct packed {
    carry_t c;
    logic   hi;
  } pdiv_side_t;

  localparam int unsigned SW = $bits(pdiv_side_t);

  // P1: B6 = B5 - 4000
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  carry_t c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic [RawPressW-1:0] up1_q, up2_q, up3_q, up4_q, up5_q;
  logic signed [31:0] b6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b6_q     <= item_i.b5 - B5_OFFSET;
      c1_q.fault <= item_i.fault;
      c1_q.t   <= item_i.t;
      up1_q    <= item_i.up;
    end
  end

  // P2: products of B6
  logic signed [31:0] sq2_q, x2a2_q, x1c2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sq2_q  <= mul_lo(b6_q, b6_q) >>> 12;
      x2a2_q <= mul_lo(coef_i.ac2, b6_q) >>> 11;
      x1c2_q <= mul_lo(coef_i.ac3, b6_q) >>> 13;
      c2_q   <= c1_q;
      up2_q  <= up1_q;
    end
  end

  // P3: products of the squared term
  logic signed [31:0] x1b3_q, x2b3_q, x2a3_q, x1c3_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x1b3_q <= mul_lo(coef_i.b2, sq2_q) >>> 11;
      x2b3_q <= mul_lo(coef_i.b1, sq2_q) >>> 16;
      x2a3_q <= x2a2_q;
      x1c3_q <= x1c2_q;
      c3_q   <= c2_q;
      up3_q  <= up2_q;
    end
  end

  // P4: sum the correction terms
  logic signed [31:0] x3_4_q, xb4_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x3_4_q <= x1b3_q + x2a3_q;
      xb4_q  <= x1c3_q + x2b3_q;
      c4_q   <= c3_q;
      up4_q  <= up3_q;
    end
  end

  // P5: B3 with truncating divide by four, X3 for B4
  logic signed [31:0] s5, b3pre, v5s, b3_d;
  logic signed [31:0] b3_q, x3b_q;

  always_comb begin
    s5    = (coef_i.ac1 <<< 2) + x3_4_q;
    b3pre = s5 <<< coef_i.oss;
    v5s   = b3pre + 32'sd2;
    b3_d  = (v5s + $signed({30'd0, {2{v5s[31]}}})) >>> 2;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b3_q  <= b3_d;
      x3b_q <= (xb4_q + 32'sd2) >>> 2;
      c5_q  <= c4_q;
      up5_q <= up4_q;
    end
  end

  // P6: B4 and UP - B3
  logic signed [31:0] b4m;
  logic [16:0]        b4_6_q;
  logic [31:0]        b7a_q;

  assign b4m = mul_lo(coef_i.ac4, x3b_q + B4_OFFSET);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b4_6_q <= b4m[31:15];
      b7a_q  <= {13'd0, up5_q} - b3_q;
      c6_q   <= c5_q;
    end
  end

  // P7: B7 scale, flag zero divisor
  logic [15:0]        scale;
  logic signed [31:0] b7m;
  logic [31:0]        b7_q;
  logic [16:0]        b4_7_q;
  carry_t             c7_q;

  assign scale = 16'(PRESS_SCALE >> coef_i.oss);
  assign b7m   = mul_lo(b7a_q, zext16(scale));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b7_q       <= b7m;
      b4_7_q     <= b4_6_q;
      c7_q.t     <= c6_q.t;
      c7_q.fault <= c6_q.fault | (b4_6_q == 17'd0);
    end
  end

  // divide B7 (doubled when it fits) by B4
  pdiv_side_t  side_in, side_out;
  logic [31:0] num, quo;
  logic        dv_vld;

  always_comb begin
    side_in.c  = c7_q;
    side_in.hi = b7_q[31];
    num        = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
  end

  bpc_div #(
    .NW(32),
    .DW(17),
    .SW(SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv_i),
    .vld_i  (v7_q),
    .num_i  (num),
    .den_i  (b4_7_q),
    .side_i (side_in),
    .vld_o  (dv_vld),
    .quo_o  (quo),
    .side_o (side_out)
  );

  // D1: P, P >> 8 and the linear term
  logic d1v_q, d2v_q, d3v_q, d4v_q;
  carry_t cd1_q, cd2_q, cd3_q;
  logic signed [31:0] p_d;
  logic signed [31:0] p1_q, x1_1_q, x2_1_q;

  assign p_d = side_out.hi ? {quo[30:0], 1'b0} : quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1v_q <= 1'b0;
      d2v_q <= 1'b0;
      d3v_q <= 1'b0;
      d4v_q <= 1'b0;
    end else if (adv_i) begin
      d1v_q <= dv_vld;
      d2v_q <= d1v_q;
      d3v_q <= d2v_q;
      d4v_q <= d3v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p1_q   <= p_d;
      x1_1_q <= p_d >>> 8;
      x2_1_q <= mul_lo(PC_LIN, p_d) >>> 16;
      cd1_q  <= side_out.c;
    end
  end

  // D2: square
  logic signed [31:0] p2_q, sqx2_q, x2_2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p2_q   <= p1_q;
      sqx2_q <= mul_lo(x1_1_q, x1_1_q);
      x2_2_q <= x2_1_q;
      cd2_q  <= cd1_q;
    end
  end

  // D3: quadratic term
  logic signed [31:0] p3_q, m3_q, x2_3_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p3_q   <= p2_q;
      m3_q   <= mul_lo(sqx2_q, PC_SQ) >>> 16;
      x2_3_q <= x2_2_q;
      cd3_q  <= cd2_q;
    end
  end

  // D4: apply correction, saturate, zero on fault
  logic signed [31:0] corr, pn;
  logic [PressW-1:0]  p_sat;
  logic signed [TempW-1:0] t4_q;
  logic [PressW-1:0]  p4_q;
  logic               f4_q;

  always_comb begin
    corr = m3_q + x2_3_q + PC_OFS;
    pn   = p3_q + (corr >>> 4);
    if (pn < 32'sd0) begin
      p_sat = '0;
    end else if (pn > PRESS_MAX) begin
      p_sat = PRESS_MAX[PressW-1:0];
    end else begin
      p_sat = pn[PressW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      f4_q <= cd3_q.fault;
      t4_q <= cd3_q.fault ? '0 : cd3_q.t;
      p4_q <= cd3_q.fault ? '0 : p_sat;
    end
  end

  assign vld_o   = d4v_q;
  assign temp_o  = t4_q;
  assign press_o = p4_q;
  assign fault_o = f4_q;

  `BPC_ASSERT_IMP(a_fault_zero, d4v_q && f4_q, (t4_q == '0) && (p4_q == '0),
                  "faulted word carries nonzero results")
  `BPC_ASSERT(a_out_hold, !adv_i |=> $stable(d4v_q) && $stable(p4_q),
              "output word changed while held")

endmodule

// ===== rtl/barometric_pressure_compensation_core.sv =====
// ---------------------------------------------------------------------------
// barometric_pressure_compensation_core
// Integer compensation of raw barometric temperature and pressure words.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: raw_temp_i / raw_press_i qualified by in_valid_i; a word
//   is taken at a clock edge with in_valid_i high and in_stall_o low.
//   Output channel: temp_tenths_o, press_pa_o, div_fault_o qualified by
//   out_valid_o; the word is taken when out_stall_i is low.
//   Configuration: write cfg_data_i into register cfg_idx_i while cfg_we_i
//   is high; write only while no word is in flight.
//   A word passes 75 register stages from the accepting edge to out_valid_o
//   (the first loaded at acceptance). Throughput is one word per cycle
//   while the output is not stalled; the two 27- and 32-stage dividers set the depth.
//   Reset clears all valid bits and the calibration words; oversampling
//   comes up as 1.
//   While the output word is stalled the whole pipeline holds and
//   in_stall_o is raised; nothing is dropped or repeated.
//   A zero divisor returns div_fault_o = 1 with zero temperature/pressure.
// ---------------------------------------------------------------------------
module barometric_pressure_compensation_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [bpc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bpc_pkg::RawTempW-1:0]     raw_temp_i,
  input  logic [bpc_pkg::RawPressW-1:0]    raw_press_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [bpc_pkg::TempW-1:0] temp_tenths_o,
  output logic [bpc_pkg::PressW-1:0]       press_pa_o,
  output logic                             div_fault_o
);
  import bpc_pkg::*;

  // configuration registers
  logic [63:0] coef_a_q, coef_b_q;
  logic [31:0] coef_c_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= '0;
      coef_b_q <= '0;
      coef_c_q <= '0;
      oss_q    <= 2'd1;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_COEF_A: coef_a_q <= cfg_data_i;
        REG_COEF_B: coef_b_q <= cfg_data_i;
        REG_COEF_C: coef_c_q <= cfg_data_i[31:0];
        REG_OSS:    oss_q    <= cfg_data_i[1:0];
        default:    ;
      endcase
    end
  end

  // unpack calibration words
  coef_t coef;

  always_comb begin
    coef.ac1 = sext16(coef_a_q[15:0]);
    coef.ac2 = sext16(coef_a_q[31:16]);
    coef.ac3 = sext16(coef_a_q[47:32]);
    coef.ac4 = zext16(coef_a_q[63:48]);
    coef.ac5 = zext16(coef_b_q[15:0]);
    coef.ac6 = zext16(coef_b_q[31:16]);
    coef.b1  = sext16(coef_b_q[47:32]);
    coef.b2  = sext16(coef_b_q[63:48]);
    coef.mc  = sext16(coef_c_q[15:0]);
    coef.md  = sext16(coef_c_q[31:16]);
    coef.oss = oss_q;
  end

  // hold the whole pipeline while the output word is stalled
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic       t_vld;
  temp_item_t t_item;

  bpc_temp u_temp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .vld_i       (in_valid_i),
    .raw_temp_i  (raw_temp_i),
    .raw_press_i (raw_press_i),
    .coef_i      (coef),
    .vld_o       (t_vld),
    .item_o      (t_item)
  );

  bpc_press u_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .vld_i   (t_vld),
    .item_i  (t_item),
    .coef_i  (coef),
    .vld_o   (out_valid_o),
    .temp_o  (temp_tenths_o),
    .press_o (press_pa_o),
    .fault_o (div_fault_o)
  );

endmodule

// ===== sim/pressure_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pressure_checker
// Watches the configuration port and both word channels of the pressure
// compensation core, predicts each compensated word from its own copy of
// the calibration registers, and compares the results in order.
// ---------------------------------------------------------------------------
module pressure_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [bpc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [bpc_pkg::RawTempW-1:0]     raw_temp_i,
  input  logic [bpc_pkg::RawPressW-1:0]    raw_press_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic signed [bpc_pkg::TempW-1:0] temp_tenths_i,
  input  logic [bpc_pkg::PressW-1:0]       press_pa_i,
  input  logic                             div_fault_i,
  output int                               errors_o,
  output int                               pending_o,
  output int                               checked_o,
  output int                               faults_o
);
  import bpc_pkg::*;

  typedef struct packed {
    logic [TempW-1:0]  temp;
    logic [PressW-1:0] press;
    logic              fault;
  } comp_word_t;

  logic [63:0] coef_a, coef_b;
  logic [31:0] coef_c;
  logic [1:0]  oss;
  comp_word_t  comp_words[$];

  // sign-extend the low 32 bits
  function automatic longint wrap32(input longint v);
    return longint'($signed(v[31:0]));
  endfunction

  function automatic longint sf16(input logic [15:0] v);
    return longint'($signed(v));
  endfunction

  // integer compensation chain for one raw word pair
  function automatic comp_word_t compensate(input logic [15:0] ut_raw,
                                            input logic [18:0] up_raw);
    comp_word_t  r;
    longint      ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint      ut, x1, x2, x3, den, b5, b6, sq, b3, t, p;
    logic [63:0] prod;
    logic [31:0] b4, b7, pu, up;
    ac1 = sf16(coef_a[15:0]);
    ac2 = sf16(coef_a[31:16]);
    ac3 = sf16(coef_a[47:32]);
    ac4 = longint'({48'd0, coef_a[63:48]});
    ac5 = longint'({48'd0, coef_b[15:0]});
    ac6 = longint'({48'd0, coef_b[31:16]});
    b1  = sf16(coef_b[47:32]);
    b2  = sf16(coef_b[63:48]);
    mc  = sf16(coef_c[15:0]);
    md  = sf16(coef_c[31:16]);
    ut  = longint'({48'd0, ut_raw});
    up  = {13'd0, up_raw};
    r   = '{temp: '0, press: '0, fault: 1'b1};

    // temperature
    x1  = wrap32((ut - ac6) * ac5) >>> 15;
    den = wrap32(x1 + md);
    if (den == 0) return r;
    x2 = wrap32((mc * 2048) / den);
    b5 = wrap32(x1 + x2);
    t  = wrap32(b5 + 8) >>> 4;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;

    // pressure coefficients
    b6 = wrap32(b5 - 4000);
    sq = wrap32(b6 * b6) >>> 12;
    x1 = wrap32(b2 * sq) >>> 11;
    x2 = wrap32(ac2 * b6) >>> 11;
    x3 = wrap32(x1 + x2);
    b3 = wrap32(wrap32(ac1 * 4 + x3) * (longint'(1) << oss));
    b3 = wrap32(wrap32(b3 + 2) / 4);
    x1 = wrap32(ac3 * b6) >>> 13;
    x2 = wrap32(b1 * sq) >>> 16;
    x3 = wrap32(wrap32(x1 + x2) + 2) >>> 2;
    prod = ac4 * longint'({32'd0, 32'(x3 + 32768)});
    b4 = prod[31:0] >> 15;
    if (b4 == 0) return r;
    b7   = up - 32'(b3);
    prod = {32'd0, b7} * {32'd0, 32'd50000 >> oss};
    b7   = prod[31:0];
    if (b7 < 32'h8000_0000) pu = (b7 * 32'd2) / b4;
    else pu = (b7 / b4) * 32'd2;
    p = longint'($signed(pu));

    // quadratic correction and saturation
    x1 = p >>> 8;
    x1 = wrap32(x1 * x1);
    x1 = wrap32(x1 * 3038) >>> 16;
    x2 = wrap32(-7357 * p) >>> 16;
    p  = wrap32(p + (wrap32(x1 + x2 + 3791) >>> 4));
    if (p < 0) p = 0;
    if (p > 262143) p = 262143;
    r = '{temp: t[15:0], press: p[17:0], fault: 1'b0};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("%0t mismatch %s: want %0d got %0d", $realtime, what, want, got);
    errors_o++;
  endtask

  // mirror registers, predict accepted words, compare returned words
  always @(posedge clk_i or negedge rst_ni) begin
    comp_word_t w;
    if (!rst_ni) begin
      coef_a <= '0;
      coef_b <= '0;
      coef_c <= '0;
      oss    <= 2'd1;
      comp_words.delete();
      errors_o  = 0;
      checked_o = 0;
      faults_o  = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) comp_words.push_back(compensate(raw_temp_i, raw_press_i));
      if (out_valid_i && !out_stall_i) begin
        if (comp_words.size() == 0) begin
          report_mismatch("unexpected word", 0, 1);
        end else begin
          w = comp_words.pop_front();
          checked_o++;
          if (w.fault) faults_o++;
          if (div_fault_i !== w.fault) report_mismatch("div_fault", w.fault, div_fault_i);
          if (temp_tenths_i !== $signed(w.temp))
            report_mismatch("temp_tenths", $signed(w.temp), temp_tenths_i);
          if (press_pa_i !== w.press) report_mismatch("press_pa", w.press, press_pa_i);
        end
      end
      pending_o = comp_words.size();
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_COEF_A: coef_a <= cfg_data_i;
          REG_COEF_B: coef_b <= cfg_data_i;
          REG_COEF_C: coef_c <= cfg_data_i[31:0];
          REG_OSS:    oss    <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the pressure compensation core through several calibration
// settings with directed and random raw words, random gaps and stalls.
// ---------------------------------------------------------------------------
module testbench;
  import bpc_pkg::*;

  localparam int DrainCycles = 80;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [1:0]              cfg_idx = '0;
  logic [CfgDataW-1:0]     cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [RawTempW-1:0]     raw_temp = '0;
  logic [RawPressW-1:0]    raw_press = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [TempW-1:0] temp_tenths;
  logic [PressW-1:0]       press_pa;
  logic                    div_fault;
  int                      errors, pending, checked, faults;
  int                      stall_left = 0;
  bit                      quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  barometric_pressure_compensation_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .raw_temp_i(raw_temp), .raw_press_i(raw_press),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .temp_tenths_o(temp_tenths), .press_pa_o(press_pa), .div_fault_o(div_fault)
  );

  pressure_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .raw_temp_i(raw_temp), .raw_press_i(raw_press),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .temp_tenths_i(temp_tenths), .press_pa_i(press_pa), .div_fault_i(div_fault),
    .errors_o(errors), .pending_o(pending), .checked_o(checked), .faults_o(faults)
  );

  // hold the output word for a random number of cycles after each take
  always @(posedge clk) begin
    int n;
    if (out_valid && !out_stall) begin
      n = quiet ? 0 : $urandom_range(0, 5);
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // wait until every word has returned, then let the pipe drain
  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_coeffs(input logic [63:0] a, input logic [63:0] b,
                             input logic [63:0] c, input logic [63:0] o);
    settle();
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B, b);
    write_reg(REG_COEF_C, c);
    write_reg(REG_OSS, o);
  endtask

  // offer one word, with an optional gap, and hold it until taken
  task automatic send_word(input logic [15:0] ut, input logic [18:0] up);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    raw_temp  <= ut;
    raw_press <= up;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // typical calibration set, optionally jittered
  function automatic logic [63:0] typ_a(input int j);
    return {16'd32741 + 16'($urandom_range(0, 2 * j) - j), -16'sd14383, -16'sd72, 16'sd408};
  endfunction

  function automatic logic [63:0] typ_b(input int j);
    return {16'sd4, 16'sd6190, 16'd23153 + 16'($urandom_range(0, 2 * j) - j),
            16'd32757 - 16'($urandom_range(0, j))};
  endfunction

  function automatic logic [63:0] typ_c(input bit junk);
    return {junk ? 32'($urandom) : 32'd0, 16'sd2868, -16'sd8711};
  endfunction

  initial begin
    int n_items;
    n_items = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: both divisors are zero
    send_word(16'd0, 19'd0);
    send_word(16'hFFFF, 19'h7FFFF);
    send_word(16'd27898, 19'd23843);
    in_valid <= 1'b0;

    // typical calibration, no oversampling, field extremes
    load_coeffs(typ_a(0), typ_b(0), typ_c(1'b1), 64'hFFFF_FFFF_FFFF_FFFC);
    send_word(16'd27898, 19'd23843);
    send_word(16'd0, 19'd0);
    send_word(16'hFFFF, 19'h7FFFF);
    send_word(16'd0, 19'h7FFFF);
    send_word(16'hFFFF, 19'd0);
    send_word(16'd23153, 19'd40000);
    in_valid <= 1'b0;

    // highest oversampling
    load_coeffs(typ_a(0), typ_b(0), typ_c(1'b0), 64'd3);
    send_word(16'd27898, 19'd190000);
    send_word(16'd20000, 19'h7FFFF);
    send_word(16'd40000, 19'd1);
    in_valid <= 1'b0;

    // typical calibration, oversampling 2; then all-ones calibration
    load_coeffs({16'd0, typ_a(0)}, typ_b(0), typ_c(1'b0), 64'd2);
    send_word(16'd27898, 19'd23843);
    send_word(16'd1000, 19'd5000);
    in_valid <= 1'b0;
    load_coeffs('1, '1, '1, 64'd0);
    send_word(16'd0, 19'd0);
    send_word(16'hFFFF, 19'h7FFFF);
    send_word(16'd12345, 19'd300000);
    in_valid <= 1'b0;

    // random phases: mostly realistic calibration and readings, some noise
    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph % 4 == 3);
      if (ph % 3 == 2)
        load_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom});
      else
        load_coeffs(typ_a(300), typ_b(300), typ_c(ph[0]), 64'($urandom_range(0, 3)));
      for (int k = 0; k < 150; k++) begin
        if ($urandom_range(0, 3) != 0)
          send_word(16'($urandom_range(20000, 36000)), 19'($urandom_range(10000, 400000)));
        else
          send_word(16'($urandom), 19'($urandom));
        n_items++;
      end
      in_valid <= 1'b0;
    end
    quiet = 1'b0;

    settle();
    $display("covered %0d random words over 8 calibration phases", n_items);
    $display("compared %0d words, %0d with a zero divisor", checked, faults);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_div.sv
rtl/bpc_temp.sv
rtl/bpc_press.sv
rtl/barometric_pressure_compensation_core.sv
sim/pressure_checker.sv
sim/testbench.sv
